>>> hdl/fbs_pkg.sv
// Package for the framed byte sender with echo check.
// Holds item kind codes, the command record, framing constants and queue sizes.
// No dependencies.
package fbs_pkg;

  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_ECHO    = 2'd3
  } kind_t;

  localparam logic OUT_TX   = 1'b0;
  localparam logic OUT_ECHO = 1'b1;

  localparam logic [7:0] SYNC_HEAD   = 8'hAA;
  localparam logic [7:0] SYNC_TAIL   = 8'h55;
  localparam logic [7:0] INVERT_MASK = 8'hFF;

  localparam int ECHO_QUEUE_DEPTH = 8;
  localparam int EQ_PTR_W         = $clog2(ECHO_QUEUE_DEPTH);
  localparam int EQ_FILL_W        = $clog2(ECHO_QUEUE_DEPTH + 1);

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CF_PTR_W       = $clog2(CMD_FIFO_DEPTH);
  localparam int CF_CNT_W       = $clog2(CMD_FIFO_DEPTH + 1);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

endpackage

>>> hdl/fbs_item_if.sv
// Input channel: one transaction carries one item (kind, id, payload, echo).
// No dependencies.
interface fbs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] frame_id;
  logic [7:0] payload_byte;
  logic [7:0] echo_byte;

  modport source (output valid, kind, frame_id, payload_byte, echo_byte, input ready);
  modport sink   (input valid, kind, frame_id, payload_byte, echo_byte, output ready);
endinterface

>>> hdl/fbs_result_if.sv
// Output channel: one transaction carries one result (tx byte or echo verdict
// plus status). No dependencies.
interface fbs_result_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic        run_last;
  logic        echo_good;
  logic        frame_failed;
  logic [31:0] frames_sent;
  logic [31:0] bad_frames;
  logic        queue_overflowed;

  modport source (output valid, out_kind, tx_byte, run_last, echo_good, frame_failed,
                  frames_sent, bad_frames, queue_overflowed, input ready);
  modport sink   (input valid, out_kind, tx_byte, run_last, echo_good, frame_failed,
                  frames_sent, bad_frames, queue_overflowed, output ready);
endinterface

>>> hdl/fbs_front.sv
// Front end: accepts input transactions into a register and classifies them
// into commands. Depends on fbs_pkg and fbs_item_if.
module fbs_front (
  input  logic           clk,
  input  logic           rst,
  fbs_item_if.sink       item,
  output logic           cmd_valid,
  output fbs_pkg::cmd_t  cmd,
  input  logic           cmd_ready
);

  fbs_pkg::cmd_t cmd_in;
  logic          accept;

  always_comb begin
    cmd_in.kind = fbs_pkg::kind_t'(item.kind);
    unique case (cmd_in.kind)
      fbs_pkg::KIND_BEGIN:   cmd_in.data = item.frame_id;
      fbs_pkg::KIND_PAYLOAD: cmd_in.data = item.payload_byte;
      fbs_pkg::KIND_ECHO:    cmd_in.data = item.echo_byte;
      default:               cmd_in.data = 8'h00;
    endcase
  end

  assign item.ready = !cmd_valid || cmd_ready;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_in;
    end
  end

endmodule

>>> hdl/fbs_cmd_fifo.sv
// Short command queue between front and back ends.
// Depends on fbs_pkg.
module fbs_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fbs_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output logic           head_valid,
  output fbs_pkg::cmd_t  head_cmd
);

  fbs_pkg::cmd_t                  mem [fbs_pkg::CMD_FIFO_DEPTH];
  logic [fbs_pkg::CF_PTR_W-1:0]   wr_ptr;
  logic [fbs_pkg::CF_PTR_W-1:0]   rd_ptr;
  logic [fbs_pkg::CF_CNT_W-1:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = count != fbs_pkg::CF_CNT_W'(fbs_pkg::CMD_FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == fbs_pkg::CF_PTR_W'(fbs_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                               : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == fbs_pkg::CF_PTR_W'(fbs_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                               : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> hdl/fbs_back.sv
// Back end: expands commands into results, keeps checksum, echo expectation
// queue, counters and the output register. Depends on fbs_pkg, fbs_result_if.
module fbs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           cfg_data,
  input  logic           cmd_valid,
  input  fbs_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  fbs_result_if.source   result
);

  localparam int OW = fbs_pkg::EQ_FILL_W + 2;

  logic                          check_en;
  logic [7:0]                    running_sum;
  logic [7:0]                    inv_prev;
  logic [8:0]                    eq_mem [fbs_pkg::ECHO_QUEUE_DEPTH];
  logic [fbs_pkg::EQ_PTR_W-1:0]  eq_head;
  logic [fbs_pkg::EQ_PTR_W-1:0]  eq_tail;
  logic [fbs_pkg::EQ_FILL_W-1:0] eq_fill;
  logic                          err_pending;
  logic [31:0]                   sent_cnt;
  logic [31:0]                   failed_cnt;
  logic                          ovf_flag;
  logic                          ovf_hold;
  logic [1:0]                    step;

  logic        fire;
  logic        multi;
  logic        last_step;
  logic        is_tx;
  logic [7:0]  tx_val;
  logic        last_mark;
  logic        eq_full;
  logic        eq_empty;
  logic [8:0]  eq_entry;
  logic        good;
  logic        pend_eff;
  logic        failed;
  logic [OW-1:0] fill_after;
  logic        ovf_status;

  assign fire      = cmd_valid && (!result.valid || result.ready);
  assign multi     = (cmd.kind == fbs_pkg::KIND_BEGIN) || (cmd.kind == fbs_pkg::KIND_END);
  assign last_step = !multi || (step == 2'd2);
  assign is_tx     = cmd.kind != fbs_pkg::KIND_ECHO;
  assign cmd_pop   = fire && last_step;
  assign eq_full   = eq_fill == fbs_pkg::EQ_FILL_W'(fbs_pkg::ECHO_QUEUE_DEPTH);
  assign eq_empty  = eq_fill == '0;
  assign eq_entry  = eq_mem[eq_head];
  assign last_mark = (cmd.kind == fbs_pkg::KIND_END) && (step == 2'd2);

  always_comb begin
    unique case (cmd.kind)
      fbs_pkg::KIND_BEGIN:   tx_val = (step == 2'd2) ? cmd.data : fbs_pkg::SYNC_HEAD;
      fbs_pkg::KIND_PAYLOAD: tx_val = cmd.data;
      fbs_pkg::KIND_END:     tx_val = (step == 2'd2) ? running_sum : fbs_pkg::SYNC_TAIL;
      default:               tx_val = 8'h00;
    endcase
  end

  always_comb begin
    good     = !check_en || eq_empty || (cmd.data == eq_entry[7:0]);
    pend_eff = err_pending || !good;
    failed   = !eq_empty && eq_entry[8] && pend_eff;
  end

  // overflow as seen after all pushes of this item
  always_comb begin
    fill_after = OW'(eq_fill) + (multi ? OW'(3) : OW'(1));
    if (!is_tx) begin
      ovf_status = ovf_flag;
    end else if (step == 2'd0) begin
      ovf_status = ovf_flag || (fill_after > OW'(fbs_pkg::ECHO_QUEUE_DEPTH));
    end else begin
      ovf_status = ovf_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_en    <= 1'b1;
      running_sum <= '0;
      inv_prev    <= '0;
      eq_head     <= '0;
      eq_tail     <= '0;
      eq_fill     <= '0;
      err_pending <= 1'b0;
      sent_cnt    <= '0;
      failed_cnt  <= '0;
      ovf_flag    <= 1'b0;
      ovf_hold    <= 1'b0;
      step        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        check_en <= cfg_data;
      end
      if (fire) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (fire) begin
        step     <= last_step ? 2'd0 : step + 2'd1;
        ovf_hold <= ovf_status;
        if (is_tx) begin
          inv_prev <= tx_val ^ fbs_pkg::INVERT_MASK;
          if (eq_full) begin
            ovf_flag <= 1'b1;
          end else begin
            eq_tail <= (eq_tail == fbs_pkg::EQ_PTR_W'(fbs_pkg::ECHO_QUEUE_DEPTH - 1)) ? '0
                                                                                      : eq_tail + 1'b1;
            eq_fill <= eq_fill + 1'b1;
          end
          if (cmd.kind == fbs_pkg::KIND_BEGIN && step == 2'd0) begin
            running_sum <= '0;
          end
          if (cmd.kind == fbs_pkg::KIND_PAYLOAD) begin
            running_sum <= running_sum + cmd.data;
          end
          if (last_mark) begin
            sent_cnt <= sent_cnt + 32'd1;
          end
        end else if (!eq_empty) begin
          eq_head <= (eq_head == fbs_pkg::EQ_PTR_W'(fbs_pkg::ECHO_QUEUE_DEPTH - 1)) ? '0
                                                                                    : eq_head + 1'b1;
          eq_fill <= eq_fill - 1'b1;
          if (eq_entry[8]) begin
            err_pending <= 1'b0;
            if (failed) begin
              failed_cnt <= failed_cnt + 32'd1;
            end
          end else begin
            err_pending <= pend_eff;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_tx && !eq_full) begin
      eq_mem[eq_tail] <= {last_mark, inv_prev};
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.out_kind         <= is_tx ? fbs_pkg::OUT_TX : fbs_pkg::OUT_ECHO;
      result.tx_byte          <= is_tx ? tx_val : 8'h00;
      result.run_last         <= last_step;
      result.echo_good        <= !is_tx && good;
      result.frame_failed     <= !is_tx && failed;
      result.frames_sent      <= (cmd.kind == fbs_pkg::KIND_END) ? sent_cnt + 32'd1 : sent_cnt;
      result.bad_frames       <= (!is_tx && failed) ? failed_cnt + 32'd1 : failed_cnt;
      result.queue_overflowed <= ovf_status;
    end
  end

endmodule

>>> hdl/framed_byte_sender_with_echo_check.sv
// Top level of the framed byte sender with echo check.
// Depends on fbs_pkg, fbs_item_if, fbs_result_if, fbs_front, fbs_cmd_fifo, fbs_back.
//
// Usage:
//   item   : valid/ready input channel. kind 0 begins a frame (AA AA id),
//            1 sends a payload byte, 2 ends it (55 55 sum), 3 delivers an
//            echo byte from the partner for checking.
//   result : valid/ready output channel. Each transmitted byte or echo
//            verdict is one transaction; run_last marks the last result of
//            an item. Status counters reflect the state after that item.
//   cfg_write/cfg_data : sets echo_check_enable (reset 1); write only when idle.
// Path: each item passes the input register, which loads on the accepting edge,
// then the command queue, then the output register that drives result.valid.
// Throughput: the back end emits one result per cycle while the receiver takes them, so
// payload and echo items give one result each and begin/end items give three.
// The front keeps accepting while the four-entry command queue has room, so
// input and output stall independently; a stalled receiver holds the result
// register and backs up the queue until item.ready drops.
// Reset: synchronous; clears counters, checksum, echo queue fill and flags.
module framed_byte_sender_with_echo_check (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_data,
  fbs_item_if.sink     item,
  fbs_result_if.source result
);

  logic          fr_valid;
  fbs_pkg::cmd_t fr_cmd;
  logic          fr_ready;
  logic          q_valid;
  fbs_pkg::cmd_t q_cmd;
  logic          q_pop;

  fbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (fr_valid),
    .cmd       (fr_cmd),
    .cmd_ready (fr_ready)
  );

  fbs_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_cmd   (fr_cmd),
    .push_ready (fr_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  fbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .result    (result)
  );

endmodule

>>> verif/fbs_frame_checker.sv
`timescale 1ns / 100ps
// Checker for framed_byte_sender_with_echo_check: predicts the tx bytes and echo verdicts
// of each accepted item transaction and compares every accepted result transaction.
// Depends on fbs_pkg, fbs_item_if and fbs_result_if.
module fbs_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  fbs_item_if        item,
  fbs_result_if      result,
  output int         errors,
  output int         pending,
  output int         echo_fill,
  output logic [7:0] echo_hint
);

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        run_last;
    logic        echo_good;
    logic        frame_failed;
    logic [31:0] frames_sent;
    logic [31:0] bad_frames;
    logic        queue_overflowed;
  } link_result_t;

  link_result_t results_due[$];
  link_result_t want;
  logic [8:0]   echo_expected[$];
  logic         check_en;
  logic [7:0]   checksum;
  logic [7:0]   inv_last;
  logic         err_pending;
  logic         overflowed;
  logic [31:0]  frames_done;
  logic [31:0]  frames_bad;

  task automatic predict_item(input fbs_pkg::kind_t k, input logic [7:0] id, pay, eb);
    logic [7:0]   sends[$];
    link_result_t batch[$];
    link_result_t r;
    logic [8:0]   oldest;
    logic         good;
    logic         closes_bad;
    logic         last_mark;
    good       = 1'b1;
    closes_bad = 1'b0;
    case (k)
      fbs_pkg::KIND_BEGIN: begin
        checksum = '0;
        sends.push_back(fbs_pkg::SYNC_HEAD);
        sends.push_back(fbs_pkg::SYNC_HEAD);
        sends.push_back(id);
      end
      fbs_pkg::KIND_PAYLOAD: begin
        sends.push_back(pay);
        checksum = checksum + pay;
      end
      fbs_pkg::KIND_END: begin
        sends.push_back(fbs_pkg::SYNC_TAIL);
        sends.push_back(fbs_pkg::SYNC_TAIL);
        sends.push_back(checksum);
        frames_done = frames_done + 32'd1;
      end
      default: begin
        if (echo_expected.size() > 0) begin
          oldest = echo_expected.pop_front();
          good = !check_en || (eb == oldest[7:0]);
          if (!good) err_pending = 1'b1;
          if (oldest[8]) begin
            closes_bad = err_pending;
            if (err_pending) frames_bad = frames_bad + 32'd1;
            err_pending = 1'b0;
          end
        end
        r = '0;
        r.out_kind     = fbs_pkg::OUT_ECHO;
        r.echo_good    = good;
        r.frame_failed = closes_bad;
        batch.push_back(r);
      end
    endcase
    foreach (sends[i]) begin
      last_mark = (k == fbs_pkg::KIND_END) && (i == 2);
      if (echo_expected.size() < fbs_pkg::ECHO_QUEUE_DEPTH)
        echo_expected.push_back({last_mark, inv_last});
      else
        overflowed = 1'b1;
      inv_last = sends[i] ^ fbs_pkg::INVERT_MASK;
      r = '0;
      r.out_kind = fbs_pkg::OUT_TX;
      r.tx_byte  = sends[i];
      batch.push_back(r);
    end
    foreach (batch[i]) begin
      batch[i].run_last         = (i == batch.size() - 1);
      batch[i].frames_sent      = frames_done;
      batch[i].bad_frames       = frames_bad;
      batch[i].queue_overflowed = overflowed;
      results_due.push_back(batch[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val, act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      results_due.delete();
      echo_expected.delete();
      check_en    = 1'b1;
      checksum    = '0;
      inv_last    = '0;
      err_pending = 1'b0;
      overflowed  = 1'b0;
      frames_done = '0;
      frames_bad  = '0;
      errors      = 0;
    end else begin
      if (cfg_write) check_en = cfg_data;
      if (item.valid && item.ready)
        predict_item(fbs_pkg::kind_t'(item.kind), item.frame_id, item.payload_byte,
                     item.echo_byte);
      if (result.valid && result.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual out_kind %0b tx_byte 0x%0h",
                   $time, result.out_kind, result.tx_byte);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("out_kind", 32'(want.out_kind), 32'(result.out_kind));
          check_field("tx_byte", 32'(want.tx_byte), 32'(result.tx_byte));
          check_field("run_last", 32'(want.run_last), 32'(result.run_last));
          check_field("echo_good", 32'(want.echo_good), 32'(result.echo_good));
          check_field("frame_failed", 32'(want.frame_failed), 32'(result.frame_failed));
          check_field("frames_sent", want.frames_sent, result.frames_sent);
          check_field("bad_frames", want.bad_frames, result.bad_frames);
          check_field("queue_overflowed", 32'(want.queue_overflowed),
                      32'(result.queue_overflowed));
        end
      end
    end
    pending   = results_due.size();
    echo_fill = echo_expected.size();
    echo_hint = (echo_expected.size() > 0) ? echo_expected[0][7:0] : 8'h00;
  end

endmodule

>>> verif/framed_byte_sender_with_echo_check_tb.sv
`timescale 1ns / 100ps
// Testbench top for framed_byte_sender_with_echo_check: clock, reset, item stimulus,
// receiver stalls and the verdict. Depends on fbs_pkg, both channel interfaces,
// the block itself and fbs_frame_checker.
module framed_byte_sender_with_echo_check_tb;

  localparam int CLK_HALF_NS  = 5;
  localparam int RUN_LIMIT_NS = 2000000;
  localparam int DRAIN_CYCLES = 6;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data  = 1'b0;
  int         src_idle_pct = 0;
  int         dst_idle_pct = 0;
  int         items_sent   = 0;
  int         errors;
  int         pending;
  int         echo_fill;
  logic [7:0] echo_hint;

  fbs_item_if   item ();
  fbs_result_if result ();

  framed_byte_sender_with_echo_check dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result)
  );

  fbs_frame_checker frame_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .errors    (errors),
    .pending   (pending),
    .echo_fill (echo_fill),
    .echo_hint (echo_hint)
  );

  always #CLK_HALF_NS clk = ~clk;

  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  task automatic send_item(input fbs_pkg::kind_t k, input logic [7:0] id, pay, eb);
    while ($urandom_range(99) < src_idle_pct) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid        <= 1'b1;
    item.kind         <= k;
    item.frame_id     <= id;
    item.payload_byte <= pay;
    item.echo_byte    <= eb;
    do @(posedge clk); while (!item.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_begin(input logic [7:0] id);
    send_item(fbs_pkg::KIND_BEGIN, id, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] pay);
    send_item(fbs_pkg::KIND_PAYLOAD, 8'($urandom), pay, 8'($urandom));
  endtask

  task automatic send_end();
    send_item(fbs_pkg::KIND_END, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_echo(input logic [7:0] eb);
    send_item(fbs_pkg::KIND_ECHO, 8'($urandom), 8'($urandom), eb);
  endtask

  task automatic send_matching_echo();
    send_echo(echo_hint);
  endtask

  task automatic send_corrupt_echo();
    send_echo(echo_hint ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic send_likely_echo();
    if ($urandom_range(99) < 92) send_matching_echo();
    else send_corrupt_echo();
  endtask

  // keep the echo queue from overflowing before the item that needs `need` entries
  task automatic make_room(input int need);
    while (echo_fill + need > fbs_pkg::ECHO_QUEUE_DEPTH) send_likely_echo();
  endtask

  task automatic wait_drained();
    item.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_check_enable(input logic en);
    cfg_write <= 1'b1;
    cfg_data  <= en;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_traffic(input int budget);
    int stop_at;
    int npay;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        make_room(3);
        send_begin(8'($urandom));
        npay = ($urandom_range(4) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
        repeat (npay) begin
          if ($urandom_range(2) == 0) send_likely_echo();
          make_room(1);
          send_payload(8'($urandom));
        end
        make_room(3);
        send_end();
      end else begin
        case ($urandom_range(3))
          0: begin
            make_room(3);
            send_begin(8'($urandom));
          end
          1: begin
            make_room(1);
            send_payload(8'($urandom));
          end
          2: begin
            make_room(3);
            send_end();
          end
          default: send_echo(8'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    item.valid        = 1'b0;
    item.kind         = fbs_pkg::KIND_BEGIN;
    item.frame_id     = '0;
    item.payload_byte = '0;
    item.echo_byte    = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct = 15;
    dst_idle_pct = 65;
    write_check_enable(1'b1);

    // directed: empty-queue echo, extremes, bad frame, exactly full queue
    send_echo(8'hFF);
    send_begin(8'h00);
    repeat (3) send_matching_echo();
    send_payload(8'hFF);
    send_payload(8'h00);
    send_matching_echo();
    send_corrupt_echo();
    send_end();
    repeat (3) send_matching_echo();
    send_begin(8'hFF);
    send_payload(8'h80);
    send_payload(8'h90);
    send_end();
    repeat (8) send_matching_echo();

    wait_drained();
    random_traffic(60);

    wait_drained();
    write_check_enable(1'b0);
    src_idle_pct = 65;
    dst_idle_pct = 15;
    random_traffic(30);
    wait_drained();
    random_traffic(30);

    wait_drained();
    write_check_enable(1'b1);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_traffic(40);

    // overflow: the checksum expectation of this frame is dropped, so its bad echo
    // is charged to the next frame that closes
    make_room(fbs_pkg::ECHO_QUEUE_DEPTH);
    send_begin(8'h5A);
    repeat (3) send_payload(8'($urandom));
    send_end();
    send_payload(8'($urandom));
    send_corrupt_echo();
    while (echo_fill != 0) send_matching_echo();
    send_begin(8'hC3);
    send_payload(8'($urandom));
    send_end();
    while (echo_fill != 0) send_matching_echo();
    send_echo(8'($urandom));

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
